[rtl/ddpi_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package ddpi_pkg;

  typedef enum logic [2:0] {
    CFG_HEADING_GAIN   = 3'd0,
    CFG_DISTANCE_GAIN  = 3'd1,
    CFG_DONE_THRESHOLD = 3'd2,
    CFG_DISTANCE_LIMIT = 3'd3,
    CFG_SPEED_LIMIT    = 3'd4,
    CFG_ENCODER_LIMIT  = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_REBASE,
    ST_READ,
    ST_MUL,
    ST_DIV,
    ST_DIVH,
    ST_FINISH,
    ST_OUT
  } state_e;

  localparam int unsigned HeadingHalf = 2880;
  localparam int unsigned HeadingFull = 5760;

  // The reciprocal of 100 scaled by 2^38 and rounded up; the same constant is 1/400
  // scaled by 2^40. Both give exact quotients for magnitudes below 2^31.
  localparam logic [31:0] RecipHundred = 32'd2748779070;
  localparam int unsigned ShiftBy100   = 38;
  localparam int unsigned ShiftBy400   = 40;

  // Commands sent from the sequencer to the divider unit.
  typedef struct packed {
    logic        start;
    logic signed [47:0] dividend;
    logic        div400;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic signed [47:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

[rtl/differential_drive_pi_controller.sv]
`timescale 1ns / 1ps
`default_nettype none
// A control tick passes through two rebase steps, a multiply step, two reciprocal divisions
// and a finish step before its result is offered; the next beat is taken only after that
// result has been taken.
// A start item clears one window entry a cycle over the longer window, and no beat is
// taken until that sweep ends. A result waits in the output register until taken.
// Reset loads the register defaults and clears goals, sums and slots; the window
// memories are cleared by a pass over the longer window after reset.
module differential_drive_pi_controller
  import ddpi_pkg::*;
#(
  parameter int unsigned HEADING_WINDOW  = 1000,
  parameter int unsigned DISTANCE_WINDOW = 50
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               cfg_we_i,
  input  wire  [2:0]        cfg_index_i,
  input  wire  [14:0]       cfg_data_i,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  wire               mode_i,
  input  wire signed [13:0] heading_i,
  input  wire signed [15:0] right_count_i,
  input  wire signed [15:0] left_count_i,
  input  wire signed [13:0] goal_heading_i,
  input  wire signed [15:0] goal_distance_i,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output logic              done_res_o,
  output logic [11:0]       right_speed_o,
  output logic              right_backward_o,
  output logic [11:0]       left_speed_o,
  output logic              left_backward_o,
  output logic              rebase_o,
  output logic signed [15:0] new_right_count_o,
  output logic signed [15:0] new_left_count_o,
  output logic signed [12:0] distance_drive_o
);

  localparam int unsigned HW = (HEADING_WINDOW > 1) ? $clog2(HEADING_WINDOW) : 1;
  localparam int unsigned DW = (DISTANCE_WINDOW > 1) ? $clog2(DISTANCE_WINDOW) : 1;
  localparam int unsigned CW = (HEADING_WINDOW > DISTANCE_WINDOW) ? HW : DW;
  localparam int unsigned ClearLen = (HEADING_WINDOW > DISTANCE_WINDOW) ? HEADING_WINDOW
                                                                        : DISTANCE_WINDOW;

  logic [9:0]  hgain_q;
  logic [7:0]  dgain_q;
  logic [12:0] thr_q;
  logic [11:0] dlim_q, slim_q;
  logic [14:0] elim_q;

  state_e state_q, state_d;

  logic signed [13:0] thead_q;
  logic signed [15:0] tdist_q;
  logic signed [27:0] hsum_q;
  logic signed [25:0] dsum_q;
  logic [HW-1:0] hslot_q;
  logic [DW-1:0] dslot_q;
  logic [CW-1:0] clr_q;

  logic signed [13:0] head_q;
  logic signed [16:0] r_q, l_q;
  logic               rb_q;
  logic signed [15:0] e_q;
  logic signed [17:0] d_q;
  logic signed [47:0] dnum_c, hnum_q;
  logic signed [13:0] drive_q;

  logic signed [17:0] hmem [HEADING_WINDOW];
  logic signed [20:0] dmem [DISTANCE_WINDOW];
  logic signed [17:0] hold_q;
  logic signed [20:0] dold_q;

  div_req_t req;
  div_rsp_t rsp;

  ddpi_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(req), .rsp_o(rsp));

  logic in_acc, out_acc;
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_acc) state_d = mode_i ? ST_REBASE : ST_CLEAR;
      ST_CLEAR:  if (32'(clr_q) == ClearLen - 1) state_d = ST_IDLE;
      ST_REBASE: state_d = ST_READ;
      ST_READ:   state_d = ST_MUL;
      ST_MUL:    state_d = ST_DIV;
      ST_DIV:    if (rsp.done) state_d = ST_DIVH;
      ST_DIVH:   if (rsp.done) state_d = ST_FINISH;
      ST_FINISH: state_d = ST_OUT;
      ST_OUT:    if (out_acc) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_stall_o  = (state_q != ST_IDLE);
    out_valid_o = (state_q == ST_OUT);
    req.start    = 1'b0;
    req.dividend = dnum_c;
    req.div400   = 1'b0;
    if (state_q == ST_MUL) begin
      req.start = 1'b1;
    end else if (state_q == ST_DIV && rsp.done) begin
      req.start    = 1'b1;
      req.dividend = hnum_q;
      req.div400   = 1'b1;
    end
  end

  // Rebase step on the held counts.
  logic               rb_hi, rb_lo;
  logic signed [16:0] half_sum;
  logic signed [16:0] lim_s;
  assign lim_s    = 17'(elim_q);
  assign rb_hi    = (r_q > lim_s) || (l_q > lim_s);
  assign rb_lo    = (r_q < -lim_s) || (l_q < -lim_s);
  assign half_sum = (r_q / 2) + (l_q / 2);

  logic signed [15:0] e_raw;
  logic signed [15:0] e_wr;
  logic signed [17:0] rl_sum;
  logic signed [17:0] d_c;
  assign e_raw  = 16'(thead_q) - 16'(head_q);
  assign rl_sum = 18'(r_q) + 18'(l_q);
  assign d_c    = 18'(tdist_q) - (rl_sum / 2);
  assign dnum_c = 48'(32'(d_c) * 32'sd100 * $signed({24'd0, dgain_q})) + 48'(dsum_q);
  always_comb begin
    e_wr = e_raw;
    if (e_raw > $signed(16'(HeadingHalf)))       e_wr = e_raw - 16'(HeadingFull);
    else if (e_raw < -$signed(16'(HeadingHalf))) e_wr = e_raw + 16'(HeadingFull);
  end

  logic signed [25:0] p_val;
  logic signed [13:0] drive_c;
  logic signed [20:0] rc, lc;
  logic [20:0] rmag, lmag;
  logic signed [13:0] dl_s;
  assign dl_s = 14'(dlim_q);
  assign p_val = (26'(e_q) * $signed({1'b0, hgain_q})) / 16;
  always_comb begin
    drive_c = 14'(rsp.quotient);
    if (rsp.quotient > 48'(dl_s))       drive_c = dl_s;
    else if (rsp.quotient < -48'(dl_s)) drive_c = -dl_s;
  end

  logic signed [20:0] off_c;
  assign off_c = 21'(rsp.quotient);
  assign rc   = 21'(drive_q) - off_c;
  assign lc   = 21'(drive_q) + off_c;
  assign rmag = rc[20] ? 21'(-rc) : 21'(rc);
  assign lmag = lc[20] ? 21'(-lc) : 21'(lc);

  logic [HW-1:0] hslot_n;
  logic [DW-1:0] dslot_n;
  assign hslot_n = (32'(hslot_q) >= HEADING_WINDOW - 1) ? '0 : hslot_q + 1'b1;
  assign dslot_n = (32'(dslot_q) >= DISTANCE_WINDOW - 1) ? '0 : dslot_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hgain_q <= 10'd332;
      dgain_q <= 8'd25;
      thr_q   <= 13'd1500;
      dlim_q  <= 12'd2500;
      slim_q  <= 12'd3199;
      elim_q  <= 15'd20000;
      state_q <= ST_CLEAR;
      thead_q <= '0;
      tdist_q <= '0;
      hsum_q  <= '0;
      dsum_q  <= '0;
      hslot_q <= '0;
      dslot_q <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_HEADING_GAIN:   hgain_q <= cfg_data_i[9:0];
          CFG_DISTANCE_GAIN:  dgain_q <= cfg_data_i[7:0];
          CFG_DONE_THRESHOLD: thr_q   <= cfg_data_i[12:0];
          CFG_DISTANCE_LIMIT: dlim_q  <= cfg_data_i[11:0];
          CFG_SPEED_LIMIT:    slim_q  <= cfg_data_i[11:0];
          CFG_ENCODER_LIMIT:  elim_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == ST_IDLE && in_acc && !mode_i) begin
        thead_q <= goal_heading_i;
        tdist_q <= goal_distance_i;
        hsum_q  <= '0;
        dsum_q  <= '0;
        clr_q   <= '0;
      end
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (state_q == ST_REBASE && rb_hi) tdist_q <= tdist_q - 16'(half_sum);
      if (state_q == ST_READ && rb_lo) tdist_q <= tdist_q - 16'(half_sum);
      if (state_q == ST_FINISH) begin
        dsum_q  <= dsum_q - 26'(dold_q) + 26'(21'(d_q) * 21'sd10);
        hsum_q  <= hsum_q - 28'(hold_q) + 28'(18'(e_q) * 18'sd10);
        hslot_q <= hslot_n;
        dslot_q <= dslot_n;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_acc) begin
      head_q <= heading_i;
      r_q    <= 17'(right_count_i);
      l_q    <= 17'(left_count_i);
      rb_q   <= 1'b0;
    end
    if (state_q == ST_REBASE && rb_hi) begin
      r_q  <= 17'(16'(r_q - l_q));
      l_q  <= '0;
      rb_q <= 1'b1;
    end
    if (state_q == ST_READ) begin
      if (rb_lo) begin
        r_q  <= 17'(16'(r_q - l_q));
        l_q  <= '0;
        rb_q <= 1'b1;
      end
      e_q <= e_wr;
    end
    if (state_q == ST_MUL) begin
      d_q    <= d_c;
      hnum_q <= 48'(p_val) * 48'sd400 + 48'(hsum_q) * 48'sd3;
    end
    if (state_q == ST_DIV && rsp.done) drive_q <= drive_c;
    if (state_q == ST_DIVH && rsp.done) begin
      distance_drive_o  <= 13'(drive_q);
      rebase_o          <= rb_q;
      new_right_count_o <= 16'(r_q);
      new_left_count_o  <= 16'(l_q);
      if (rmag < 21'(thr_q) && lmag < 21'(thr_q)) begin
        done_res_o <= 1'b1;
        right_speed_o <= '0; right_backward_o <= 1'b0;
        left_speed_o  <= '0; left_backward_o  <= 1'b0;
      end else begin
        done_res_o <= 1'b0;
        right_speed_o    <= (rmag > 21'(slim_q)) ? slim_q : 12'(rmag);
        right_backward_o <= !(rc > 0);
        left_speed_o     <= (lmag > 21'(slim_q)) ? slim_q : 12'(lmag);
        left_backward_o  <= !(lc > 0);
      end
    end
  end

  // Window memories: read in the rebase step, written in the finish step or swept.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLEAR) begin
      if (32'(clr_q) < HEADING_WINDOW)  hmem[HW'(clr_q)] <= '0;
      if (32'(clr_q) < DISTANCE_WINDOW) dmem[DW'(clr_q)] <= '0;
    end else if (state_q == ST_FINISH) begin
      hmem[hslot_q] <= 18'(e_q) * 18'sd10;
      dmem[dslot_q] <= 21'(d_q) * 21'sd10;
    end
    if (state_q == ST_REBASE) begin
      hold_q <= hmem[hslot_q];
      dold_q <= dmem[dslot_q];
    end
  end

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall_o) else $error("beat taken while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o) else $error("result dropped");
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(hslot_q) < HEADING_WINDOW) else $error("heading slot out of range");
  a_done_still: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && done_res_o) |-> (right_speed_o == '0 && left_speed_o == '0))
    else $error("done with moving wheels");

endmodule
`default_nettype wire

[rtl/ddpi_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// Divides by 100 or 400 through a shared reciprocal, rounding toward zero. The magnitude is
// registered, multiplied in the next cycle, and the quotient is ready once the product is registered.
module ddpi_div
  import ddpi_pkg::*;
(
  input  wire      clk_i,
  input  wire      rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic        stage_q, done_q;
  logic        neg_q, neg2_q, sel_q, sel2_q;
  logic [30:0] mag_q;
  logic [62:0] prod_q;
  logic [47:0] mag;
  logic [62:0] quo;

  assign mag = req_i.dividend[47] ? 48'(-req_i.dividend) : 48'(req_i.dividend);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      stage_q <= req_i.start;
      done_q  <= stage_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mag_q <= mag[30:0];
      neg_q <= req_i.dividend[47];
      sel_q <= req_i.div400;
    end
    if (stage_q) begin
      prod_q <= 63'(mag_q) * 63'(RecipHundred);
      neg2_q <= neg_q;
      sel2_q <= sel_q;
    end
  end

  assign quo = sel2_q ? (prod_q >> ShiftBy400) : (prod_q >> ShiftBy100);

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = neg2_q ? -$signed(48'(quo)) : $signed(48'(quo));

endmodule
`default_nettype wire
